FILE: rtl/lpht_pkg.sv
// Shared types, codes and constants of the linear probe hash table.
package lpht_pkg;

   // Field widths of the request and response words.
   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 32;
   localparam int RECORD_W = 64;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;

   // Default number of slots in the table.
   localparam int DEFAULT_TABLE_SIZE = 16;

   // Operation codes of a request word.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_SEARCH = 2'd1,
      FUNC_DELETE = 2'd2
   } func_type;

   // Status codes of a response word.
   typedef enum logic [STATUS_W-1:0] {
      RES_INSERTED  = 3'd0,
      RES_DUPLICATE = 3'd1,
      RES_FULL      = 3'd2,
      RES_FOUND     = 3'd3,
      RES_NOT_FOUND = 3'd4,
      RES_DELETED   = 3'd5
   } status_type;

   // Condition of one slot.
   typedef enum logic [1:0] {
      SLOT_EMPTY    = 2'd0,
      SLOT_OCCUPIED = 2'd1,
      SLOT_DELETED  = 2'd2
   } slot_state_type;

   // Registered read data of one slot.
   typedef struct packed {
      slot_state_type       state;
      logic [KEY_W-1:0]     key;
      logic [RECORD_W-1:0]  record;
   } rd_type;

   // Write request to one slot.
   typedef struct packed {
      logic                 state_we;
      logic                 entry_we;
      slot_state_type       state;
      logic [KEY_W-1:0]     key;
      logic [RECORD_W-1:0]  record;
   } wr_type;

endpackage

FILE: rtl/lpht_home.sv
// Home slot: the key modulo the table size, by a multiply stage and a subtract stage.
module lpht_home import lpht_pkg::*; #(
   parameter int  TABLE_SIZE = DEFAULT_TABLE_SIZE,
   localparam int IDX_W      = $clog2(TABLE_SIZE)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output logic             done,
   output logic [IDX_W-1:0] home
);

   // With this shift and the rounded-up reciprocal, the high product bits are the exact
   // quotient for every key value.
   localparam int             SHIFT = KEY_W + IDX_W;
   localparam logic [KEY_W:0] RECIP =
      (KEY_W+1)'(((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
   localparam int             PROD_W = 2 * KEY_W + 1;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic              mul_vld_ff, mul_vld_in;
   logic              done_ff, done_in;
   logic [KEY_W-1:0]  quot;
   logic [KEY_W-1:0]  quot_back;

   // Multiply stage: capture the key and multiply it by the reciprocal.
   always_comb begin
      key_in  = key_ff;
      prod_in = prod_ff;
      if (start) begin
         key_in  = key;
         prod_in = PROD_W'(key) * PROD_W'(RECIP);
      end
   end

   // Subtract stage: multiply the quotient back and keep the difference.
   assign quot      = KEY_W'(prod_ff >> SHIFT);
   assign quot_back = quot * KEY_W'(TABLE_SIZE);
   assign rem_in    = mul_vld_ff ? IDX_W'(key_ff - quot_back) : rem_ff;

   // Stage flags; done is high for one cycle while the home slot is ready.
   assign mul_vld_in = start;
   assign done_in    = mul_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         mul_vld_ff <= mul_vld_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

FILE: rtl/lpht_table.sv
// Slot state and entry memories, with the clearing pass after reset.
module lpht_table import lpht_pkg::*; #(
   parameter int  TABLE_SIZE = DEFAULT_TABLE_SIZE,
   localparam int IDX_W      = $clog2(TABLE_SIZE)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_addr,
   output rd_type           rd_data,
   input  logic [IDX_W-1:0] wr_addr,
   input  wr_type           wr,
   output logic             clear_busy
);

   slot_state_type              state_mem [TABLE_SIZE];
   logic [KEY_W+RECORD_W-1:0]   entry_mem [TABLE_SIZE];

   slot_state_type              rd_state_ff;
   logic [KEY_W+RECORD_W-1:0]   rd_entry_ff;
   logic                        clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0]            clr_addr_ff, clr_addr_in;

   // Clearing pass: one slot per cycle is marked empty after reset.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == IDX_W'(TABLE_SIZE - 1)) begin
            clr_busy_in = 1'b0;
            clr_addr_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Slot state memory with registered read.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         state_mem[clr_addr_ff] <= SLOT_EMPTY;
      end else if (wr.state_we) begin
         state_mem[wr_addr] <= wr.state;
      end
      rd_state_ff <= state_mem[rd_addr];
   end

   // Key and record memory with registered read.
   always_ff @(posedge clock) begin
      if (wr.entry_we) begin
         entry_mem[wr_addr] <= {wr.key, wr.record};
      end
      rd_entry_ff <= entry_mem[rd_addr];
   end

   assign rd_data.state  = rd_state_ff;
   assign rd_data.key    = rd_entry_ff[KEY_W+RECORD_W-1:RECORD_W];
   assign rd_data.record = rd_entry_ff[RECORD_W-1:0];
   assign clear_busy     = clr_busy_ff;

endmodule

FILE: rtl/linear_probe_hash_table_core.sv
// Top level of the linear probe hash table: sequencer, probe loop and response register.
//
//   Channel   Ports                                        Direction
//   req       req_valid, req_stall, req_func, req_key_in,   in
//             req_record_in
//   rsp       rsp_valid, rsp_stall, rsp_status, rsp_slot,   out
//             rsp_record_out
//
// An accepted operation has its key reduced to the home slot by a multiply and a subtract,
// enters the probe loop, waits for the registered read of the home slot, checks slots in
// turn from the home slot (at most TABLE_SIZE of them) and then loads the response
// register once it is free or being read. An unused operation code goes straight to the
// response register. After reset a clearing pass marks every slot empty; req_stall
// stays high meanwhile. A waiting response does not block the next request word.
module linear_probe_hash_table_core import lpht_pkg::*; #(
   parameter int TABLE_SIZE = DEFAULT_TABLE_SIZE
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [KEY_W-1:0]    req_key_in,
   input  logic [RECORD_W-1:0] req_record_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [RECORD_W-1:0] rsp_record_out
);

   localparam int IDX_W = $clog2(TABLE_SIZE);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_HASH   = 4'b0010,
      ST_PROBE  = 4'b0100,
      ST_FINISH = 4'b1000
   } fsm_state_type;

   fsm_state_type        fsm_ff, fsm_in;
   func_type             func_ff, func_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [RECORD_W-1:0]  record_ff, record_in;
   logic [IDX_W-1:0]     issue_pos_ff, issue_pos_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]     chk_pos_ff, chk_pos_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   status_type           res_status_ff, res_status_in;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   logic [RECORD_W-1:0]  res_record_ff, res_record_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [RECORD_W-1:0]  rsp_record_ff, rsp_record_in;

   logic                 hash_start;
   logic                 hash_done;
   logic [IDX_W-1:0]     hash_home;
   rd_type               rd_data;
   wr_type               wr;
   logic                 clear_busy;
   logic                 req_take;
   logic                 rsp_load;
   logic                 key_match;
   logic                 last_probe;
   logic [IDX_W-1:0]     issue_next;

   lpht_home #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_home (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_key_in),
      .done  (hash_done),
      .home  (hash_home)
   );

   lpht_table #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (issue_pos_ff),
      .rd_data    (rd_data),
      .wr_addr    (chk_pos_ff),
      .wr         (wr),
      .clear_busy (clear_busy)
   );

   // Handshake terms and probe helpers.
   assign req_stall  = clear_busy || (fsm_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign rsp_load   = !rsp_valid_ff || !rsp_stall;
   assign key_match  = (rd_data.key == key_ff);
   assign last_probe = (chk_idx_ff == IDX_W'(TABLE_SIZE - 1));
   assign issue_next = (issue_pos_ff == IDX_W'(TABLE_SIZE - 1)) ? '0 : issue_pos_ff + 1'b1;

   // Sequencer: accept, reduce the key, probe one slot per cycle, hand over the result.
   always_comb begin
      fsm_in        = fsm_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      record_in     = record_ff;
      issue_pos_in  = issue_pos_ff;
      chk_valid_in  = chk_valid_ff;
      chk_pos_in    = chk_pos_ff;
      chk_idx_in    = chk_idx_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_record_in = res_record_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_record_in = rsp_record_ff;
      hash_start    = 1'b0;
      wr            = '0;
      wr.key        = key_ff;
      wr.record     = record_ff;

      case (fsm_ff)
         ST_IDLE: begin
            if (req_take) begin
               func_in   = func_type'(req_func);
               key_in    = req_key_in;
               record_in = req_record_in;
               res_status_in = RES_NOT_FOUND;
               res_slot_in   = '0;
               res_record_in = '0;
               if (req_func inside {FUNC_INSERT, FUNC_SEARCH, FUNC_DELETE}) begin
                  hash_start = 1'b1;
                  fsm_in     = ST_HASH;
               end else begin
                  fsm_in = ST_FINISH;
               end
            end
         end

         ST_HASH: begin
            if (hash_done) begin
               issue_pos_in = hash_home;
               chk_valid_in = 1'b0;
               chk_idx_in   = '0;
               fsm_in       = ST_PROBE;
            end
         end

         ST_PROBE: begin
            // Reads run one slot ahead; a read past the decision is dropped.
            issue_pos_in = issue_next;
            chk_valid_in = 1'b1;
            chk_pos_in   = issue_pos_ff;
            if (chk_valid_ff) begin
               chk_idx_in = chk_idx_ff + 1'b1;
               case (func_ff)
                  FUNC_INSERT: begin
                     if (rd_data.state != SLOT_OCCUPIED) begin
                        wr.state_we   = 1'b1;
                        wr.entry_we   = 1'b1;
                        wr.state      = SLOT_OCCUPIED;
                        res_status_in = RES_INSERTED;
                        res_slot_in   = SLOT_W'(chk_pos_ff);
                        fsm_in        = ST_FINISH;
                     end else if (key_match) begin
                        res_status_in = RES_DUPLICATE;
                        res_slot_in   = SLOT_W'(chk_pos_ff);
                        fsm_in        = ST_FINISH;
                     end else if (last_probe) begin
                        res_status_in = RES_FULL;
                        fsm_in        = ST_FINISH;
                     end
                  end
                  default: begin
                     if (rd_data.state == SLOT_EMPTY) begin
                        fsm_in = ST_FINISH;
                     end else if (rd_data.state == SLOT_OCCUPIED && key_match) begin
                        res_slot_in = SLOT_W'(chk_pos_ff);
                        if (func_ff == FUNC_DELETE) begin
                           wr.state_we   = 1'b1;
                           wr.state      = SLOT_DELETED;
                           res_status_in = RES_DELETED;
                        end else begin
                           res_status_in = RES_FOUND;
                           res_record_in = rd_data.record;
                        end
                        fsm_in = ST_FINISH;
                     end else if (last_probe) begin
                        fsm_in = ST_FINISH;
                     end
                  end
               endcase
            end
         end

         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_record_in = res_record_ff;
               fsm_in        = ST_IDLE;
            end
         end

         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      record_ff     <= record_in;
      issue_pos_ff  <= issue_pos_in;
      chk_pos_ff    <= chk_pos_in;
      chk_idx_ff    <= chk_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_record_ff <= res_record_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_record_ff <= rsp_record_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_record_out = rsp_record_ff;

endmodule

FILE: sim/tb_linear_probe_hash_table_core.sv
// Self-checking testbench for the linear probe hash table core.
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_core;
   import lpht_pkg::*;

   localparam int SLOTS         = DEFAULT_TABLE_SIZE;
   localparam int RESET_CYCLES  = 9;
   localparam int POOL_SIZE     = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int TAIL_CYCLES   = 40;
   localparam int MAX_REPORTS   = 40;

   // Operation code that the block does not define.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // Expected contents of one response word.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [RECORD_W-1:0] record;
   } outcome_t;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic [FUNC_W-1:0]   req_func      = '0;
   logic [KEY_W-1:0]    req_key_in    = '0;
   logic [RECORD_W-1:0] req_record_in = '0;
   logic                rsp_stall     = 1'b0;
   logic                req_stall;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [RECORD_W-1:0] rsp_record_out;

   // Shadow copy of the slot memories.
   slot_state_type      tbl_state [SLOTS] = '{default: SLOT_EMPTY};
   logic [KEY_W-1:0]    tbl_key [SLOTS]   = '{default: '0};
   logic [RECORD_W-1:0] tbl_record [SLOTS] = '{default: '0};

   outcome_t            pending_outcomes [$];
   logic [KEY_W-1:0]    key_pool [POOL_SIZE];

   bit req_idle_on     = 1'b0;
   bit rsp_idle_on     = 1'b0;
   int rsp_hold_cycles = 0;
   int rsp_wait        = 0;
   int words_sent      = 0;
   int results_seen    = 0;
   int mismatches      = 0;
   int idle_cycles     = 0;
   int status_seen [6] = '{default: 0};

   always #5 clock = ~clock;

   linear_probe_hash_table_core #(
      .TABLE_SIZE(SLOTS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_key_in    (req_key_in),
      .req_record_in (req_record_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_record_out(rsp_record_out)
   );

   // Probe from the home slot; return the slot holding the key, or -1 on a miss.
   function automatic int find_key(input logic [KEY_W-1:0] k);
      int home;
      int p;
      home = int'(k % SLOTS);
      for (int i = 0; i < SLOTS; i++) begin
         p = (home + i) % SLOTS;
         if (tbl_state[p] == SLOT_EMPTY) return -1;
         if (tbl_state[p] == SLOT_OCCUPIED && tbl_key[p] == k) return p;
      end
      return -1;
   endfunction

   // Apply one operation to the shadow table and return the response it must give.
   function automatic outcome_t table_outcome(input logic [FUNC_W-1:0] f,
                                              input logic [KEY_W-1:0] k,
                                              input logic [RECORD_W-1:0] r);
      outcome_t o;
      int home;
      int p;
      o.status = RES_NOT_FOUND;
      o.slot   = '0;
      o.record = '0;
      case (f)
         FUNC_INSERT: begin
            // The first free or deleted slot wins unless the key shows up first.
            home = int'(k % SLOTS);
            o.status = RES_FULL;
            for (int i = 0; i < SLOTS; i++) begin
               p = (home + i) % SLOTS;
               if (tbl_state[p] != SLOT_OCCUPIED) begin
                  tbl_state[p]  = SLOT_OCCUPIED;
                  tbl_key[p]    = k;
                  tbl_record[p] = r;
                  o.status = RES_INSERTED;
                  o.slot   = SLOT_W'(p);
                  break;
               end
               if (tbl_key[p] == k) begin
                  o.status = RES_DUPLICATE;
                  o.slot   = SLOT_W'(p);
                  break;
               end
            end
         end
         FUNC_SEARCH: begin
            p = find_key(k);
            if (p >= 0) begin
               o.status = RES_FOUND;
               o.slot   = SLOT_W'(p);
               o.record = tbl_record[p];
            end
         end
         FUNC_DELETE: begin
            p = find_key(k);
            if (p >= 0) begin
               tbl_state[p] = SLOT_DELETED;
               o.status = RES_DELETED;
               o.slot   = SLOT_W'(p);
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   // Print one line per mismatch, up to a cap, and count every one.
   task automatic report_mismatch(input string what, input logic [RECORD_W-1:0] got,
                                  input logic [RECORD_W-1:0] want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("tb: mismatch on result %0d, %s: got %0h, expected %0h",
                  results_seen, what, got, want);
   endtask

   // Offer one request word, after a random gap if req_idle_on is set, and hold it until it is taken.
   task automatic send_word(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                            input logic [RECORD_W-1:0] r);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_key_in    <= k;
      req_record_in <= r;
      do @(posedge clock); while (req_stall);
      pending_outcomes.push_back(table_outcome(f, k, r));
      words_sent++;
   endtask

   // Drop valid; only called right before time advances.
   task automatic release_req();
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      int spent;
      spent = 0;
      while (pending_outcomes.size() != 0 && spent < DRAIN_LIMIT) begin
         @(posedge clock);
         spent++;
      end
   endtask

   // Random traffic over the key pool; keys not in the table get swapped out now and then.
   task automatic run_random_ops(input int count);
      logic [FUNC_W-1:0]   f;
      logic [KEY_W-1:0]    k;
      logic [RECORD_W-1:0] r;
      int pick;
      int idx;
      for (int n = 0; n < count; n++) begin
         idx = $urandom_range(0, POOL_SIZE - 1);
         if ($urandom_range(0, 7) == 0 && find_key(key_pool[idx]) < 0) begin
            key_pool[idx] = $urandom;
            // Half of the new keys crowd the last slots so chains wrap around.
            if (idx % 2) key_pool[idx][3:0] = 4'($urandom_range(13, 15));
         end
         k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         if ($urandom_range(0, 19) == 0) k = $urandom;
         r = {$urandom, $urandom};
         pick = $urandom_range(0, 99);
         if (pick < 36)      f = FUNC_INSERT;
         else if (pick < 66) f = FUNC_SEARCH;
         else if (pick < 95) f = FUNC_DELETE;
         else                f = FUNC_UNUSED;
         send_word(f, k, r);
      end
   endtask

   // Extreme keys and records, a duplicate, and the unused operation code.
   task automatic test_extremes();
      send_word(FUNC_INSERT, 32'h0000_0000, 64'h0);
      send_word(FUNC_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(FUNC_INSERT, 32'h0000_0000, 64'h1234_5678_9ABC_DEF0);
      send_word(FUNC_SEARCH, 32'hFFFF_FFFF, 64'h0);
      send_word(FUNC_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   // Deleted marks keep chains intact, get reused, and probes wrap past the last slot.
   task automatic test_delete_chains();
      send_word(FUNC_INSERT, 32'h0000_0010, 64'hA5A5_5A5A_0F0F_F0F0);
      send_word(FUNC_DELETE, 32'h0000_0000, 64'h0);
      send_word(FUNC_SEARCH, 32'h0000_0010, 64'h0);
      send_word(FUNC_INSERT, 32'h0000_001F, 64'h0000_0000_DEAD_BEEF);
      send_word(FUNC_SEARCH, 32'h0000_0020, 64'h0);
   endtask

   // Fill every slot, overflow once, then miss on a full table.
   task automatic test_table_full();
      int tries;
      int n;
      tries = 0;
      do begin
         send_word(FUNC_INSERT, $urandom, {$urandom, $urandom});
         tries++;
      end while (pending_outcomes[$].status != RES_FULL && tries < 2 * SLOTS);
      send_word(FUNC_SEARCH, 32'h0BAD_0001, 64'h0);
      // Seed the random key pool with the stored keys so they can be removed later.
      n = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (tbl_state[i] == SLOT_OCCUPIED && n < POOL_SIZE) begin
            key_pool[n] = tbl_key[i];
            n++;
         end
      end
      while (n < POOL_SIZE) begin
         key_pool[n] = $urandom;
         n++;
      end
   endtask

   task automatic test_back_to_back();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_random_ops(400);
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_receiver_hold();
      req_idle_on = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      run_random_ops(40);
   endtask

   // Random gaps on both sides, with some stretches left without gaps.
   task automatic test_random_gaps();
      for (int chunk = 0; chunk < 10; chunk++) begin
         req_idle_on = (chunk % 4) != 3;
         rsp_idle_on = (chunk % 3) != 2;
         run_random_ops(145);
      end
   endtask

   // The sender goes quiet until every outstanding word has come back.
   task automatic test_sender_pause();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      for (int round = 0; round < 4; round++) begin
         run_random_ops(10);
         release_req();
         wait_for_results();
      end
   endtask

   // Receiver: random stall per word, or a long hold when a test asks for one.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) rsp_wait = rsp_idle_on ? $urandom_range(0, 5) : 0;
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted response word with the oldest expectation.
   always @(posedge clock) begin
      outcome_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_status < 6) status_seen[rsp_status]++;
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected word, status", RECORD_W'(rsp_status), '0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", RECORD_W'(rsp_status), RECORD_W'(want.status));
            if (rsp_slot !== want.slot)
               report_mismatch("slot", RECORD_W'(rsp_slot), RECORD_W'(want.slot));
            if (rsp_record_out !== want.record)
               report_mismatch("record_out", rsp_record_out, want.record);
         end
      end
   end

   // Watchdog: too many cycles without any word moving ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: timeout with %0d words outstanding", pending_outcomes.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Test sequence.
   initial begin
      outcome_t left;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_delete_chains();
      test_table_full();
      test_back_to_back();
      test_receiver_hold();
      test_random_gaps();
      test_sender_pause();

      release_req();
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      while (pending_outcomes.size() != 0) begin
         left = pending_outcomes.pop_front();
         report_mismatch("missing word, status", '0, RECORD_W'(left.status));
      end

      $display("tb: %0d words sent, %0d checked, %0d mismatches",
               words_sent, results_seen, mismatches);
      $display("tb: inserted %0d, duplicate %0d, full %0d, found %0d, missed %0d, deleted %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5]);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/lpht_pkg.sv
rtl/lpht_home.sv
rtl/lpht_table.sv
rtl/linear_probe_hash_table_core.sv
sim/tb_linear_probe_hash_table_core.sv
